FILE: rtl/ectp_pkg.sv
// Shared constants and types for the edge-collapse triangle penalty block.
// No dependencies; imported by the interfaces, the datapath and the top level.
package ectp_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 16;

  // Width of one multiplier operand slice in the wide product pipeline
  localparam int MUL_CHUNK = 16;

  // Point slots in the flattened coordinate array (x, y, z follow each base)
  localparam int NUM_PTS = 12;
  localparam int P_NEW   = 0;
  localparam int P_OLD   = 3;
  localparam int P_LEFT  = 6;
  localparam int P_RIGHT = 9;

  // Pipeline control from the top level to the datapath
  typedef struct packed {
    logic adv;    // all stages move one step
    logic valid;  // input transfer this cycle
  } ectp_ctl_t;

endpackage

FILE: rtl/ectp_if.sv
// Valid/ready channel interfaces for triangle items and penalty results.
// Depends on ectp_pkg for default widths.
interface ectp_in_if import ectp_pkg::*; #(
  parameter int CB = COORD_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] new_x, new_y, new_z;
  logic signed [CB-1:0] old_x, old_y, old_z;
  logic signed [CB-1:0] left_x, left_y, left_z;
  logic signed [CB-1:0] right_x, right_y, right_z;

  modport source (output valid, new_x, new_y, new_z, old_x, old_y, old_z,
                  left_x, left_y, left_z, right_x, right_y, right_z,
                  input ready);
  modport sink (input valid, new_x, new_y, new_z, old_x, old_y, old_z,
                left_x, left_y, left_z, right_x, right_y, right_z,
                output ready);
endinterface

interface ectp_out_if import ectp_pkg::*; #(
  parameter int FB = FRAC_BITS_DEF
);
  logic        valid;
  logic        ready;
  logic        deny;
  logic [FB:0] penalty;

  modport source (output valid, deny, penalty, input ready);
  modport sink (input valid, deny, penalty, output ready);
endinterface

FILE: rtl/ectp_datapath.sv
// Pipelined arithmetic: edge vectors, normals, sliced wide products,
// digit-by-digit square roots, restoring dividers and the penalty select.
// Depends on ectp_pkg.
module ectp_datapath import ectp_pkg::*; #(
  parameter int CB = COORD_BITS_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ectp_ctl_t            ctl,
  input  logic signed [CB-1:0] pts [NUM_PTS],
  input  logic [FB:0]          target,
  output logic                 out_valid,
  output logic                 out_deny,
  output logic [FB:0]          out_penalty
);

  localparam int DW   = CB + 1;          // edge vector component
  localparam int NW   = 2 * DW;          // normal component
  localparam int SQW  = 2 * CB + 1;      // one squared component
  localparam int SW   = 2 * CB + 4;      // sum of squared edge lengths
  localparam int NC   = (NW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int BXW  = NC * MUL_CHUNK;
  localparam int PW   = 2 * NW;          // wide product and sum of squares
  localparam int XW   = PW + 4 + 2 * FB; // radicand, always even
  localparam int RW   = XW / 2;          // root
  localparam int REMW = RW + 3;
  localparam int CW   = SW + FB + 1;     // divider compare width
  localparam int QW   = FB + 1;
  localparam logic [QW-1:0] ONE = QW'(1) << FB;

  function automatic logic signed [DW-1:0] sx(input logic signed [CB-1:0] v);
    return DW'(v);
  endfunction

  function automatic logic [SQW-1:0] sq(input logic signed [DW-1:0] v);
    logic signed [NW-1:0] p;
    p = v * v;
    return p[SQW-1:0];
  endfunction

  // ---------------- stage 1: edge vectors
  logic signed [DW-1:0] a [3], bo [3], bn [3], cn [3], co [3];
  logic                 v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ctl.adv) begin
      v1 <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int i = 0; i < 3; i++) begin
        a[i]  <= sx(pts[P_RIGHT+i]) - sx(pts[P_LEFT+i]);
        bo[i] <= sx(pts[P_OLD+i])   - sx(pts[P_LEFT+i]);
        bn[i] <= sx(pts[P_NEW+i])   - sx(pts[P_LEFT+i]);
        cn[i] <= sx(pts[P_NEW+i])   - sx(pts[P_RIGHT+i]);
        co[i] <= sx(pts[P_OLD+i])   - sx(pts[P_RIGHT+i]);
      end
    end
  end

  // ---------------- stage 2: cross terms and squared components
  logic signed [NW-1:0] xo [6], xn [6];
  logic [SQW-1:0]       sqa [3], sqbn [3], sqcn [3], sqbo [3], sqco [3];
  logic                 v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ctl.adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      xo[0] <= a[1] * bo[2];  xo[1] <= a[2] * bo[1];
      xo[2] <= a[2] * bo[0];  xo[3] <= a[0] * bo[2];
      xo[4] <= a[0] * bo[1];  xo[5] <= a[1] * bo[0];
      xn[0] <= a[1] * bn[2];  xn[1] <= a[2] * bn[1];
      xn[2] <= a[2] * bn[0];  xn[3] <= a[0] * bn[2];
      xn[4] <= a[0] * bn[1];  xn[5] <= a[1] * bn[0];
      for (int i = 0; i < 3; i++) begin
        sqa[i]  <= sq(a[i]);
        sqbn[i] <= sq(bn[i]);
        sqcn[i] <= sq(cn[i]);
        sqbo[i] <= sq(bo[i]);
        sqco[i] <= sq(co[i]);
      end
    end
  end

  // ---------------- stage 3: normals and edge length sums
  logic signed [NW-1:0] nold [3], nnew [3];
  logic [SW-1:0]        sn, so, sn_sum, so_sum, sa_sum;
  logic                 snz, soz, v3;

  always_comb begin
    sa_sum = SW'(sqa[0]) + SW'(sqa[1]) + SW'(sqa[2]);
    sn_sum = sa_sum + SW'(sqbn[0]) + SW'(sqbn[1]) + SW'(sqbn[2])
           + SW'(sqcn[0]) + SW'(sqcn[1]) + SW'(sqcn[2]);
    so_sum = sa_sum + SW'(sqbo[0]) + SW'(sqbo[1]) + SW'(sqbo[2])
           + SW'(sqco[0]) + SW'(sqco[1]) + SW'(sqco[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ctl.adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      nold[0] <= xo[0] - xo[1];
      nold[1] <= xo[2] - xo[3];
      nold[2] <= xo[4] - xo[5];
      nnew[0] <= xn[0] - xn[1];
      nnew[1] <= xn[2] - xn[3];
      nnew[2] <= xn[4] - xn[5];
      sn      <= sn_sum;
      so      <= so_sum;
      snz     <= (sn_sum == '0);
      soz     <= (so_sum == '0);
    end
  end

  // ---------------- wide products, one operand slice per stage
  // lanes 0-2: old.new, lanes 3-5: new.new, lanes 6-8: old.old
  logic signed [NW-1:0] ma   [NC+1][9];
  logic [BXW-1:0]       mb   [NC+1][9];
  logic signed [PW-1:0] macc [NC+1][9];
  logic                 mv   [NC+1];
  logic [SW-1:0]        msn  [NC+1], mso [NC+1];
  logic                 msnz [NC+1], msoz [NC+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma[0][i]   = nold[i];  mb[0][i]   = BXW'(nnew[i]);
      ma[0][3+i] = nnew[i];  mb[0][3+i] = BXW'(nnew[i]);
      ma[0][6+i] = nold[i];  mb[0][6+i] = BXW'(nold[i]);
    end
    for (int l = 0; l < 9; l++) begin
      macc[0][l] = '0;
    end
    mv[0]   = v3;
    msn[0]  = sn;
    mso[0]  = so;
    msnz[0] = snz;
    msoz[0] = soz;
  end

  for (genvar j = 0; j < NC; j++) begin : g_mul
    logic signed [MUL_CHUNK:0] ck  [9];
    logic signed [PW-1:0]      pp  [9];
    logic signed [PW-1:0]      acc [9];

    // low slices are unsigned, the top slice carries the sign
    always_comb begin
      for (int l = 0; l < 9; l++) begin
        ck[l]  = (j == NC - 1)
               ? $signed({mb[j][l][BXW-1], mb[j][l][j*MUL_CHUNK +: MUL_CHUNK]})
               : $signed({1'b0, mb[j][l][j*MUL_CHUNK +: MUL_CHUNK]});
        pp[l]  = ma[j][l] * ck[l];
        acc[l] = macc[j][l] + (pp[l] <<< (MUL_CHUNK * j));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        mv[j+1] <= 1'b0;
      end else if (ctl.adv) begin
        mv[j+1] <= mv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        for (int l = 0; l < 9; l++) begin
          ma[j+1][l]   <= ma[j][l];
          mb[j+1][l]   <= mb[j][l];
          macc[j+1][l] <= acc[l];
        end
        msn[j+1]  <= msn[j];
        mso[j+1]  <= mso[j];
        msnz[j+1] <= msnz[j];
        msoz[j+1] <= msoz[j];
      end
    end
  end

  // ---------------- dot products, flip test
  logic signed [PW:0] dsum;
  logic [PW-1:0]      n2n, n2o;
  logic [SW-1:0]      dsn, dso;
  logic               ddeny, dsnz, dsoz, v4;

  assign dsum = macc[NC][0] + macc[NC][1] + macc[NC][2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ctl.adv) begin
      v4 <= mv[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      ddeny <= dsum[PW];
      n2n   <= $unsigned(macc[NC][3] + macc[NC][4] + macc[NC][5]);
      n2o   <= $unsigned(macc[NC][6] + macc[NC][7] + macc[NC][8]);
      dsn   <= msn[NC];
      dso   <= mso[NC];
      dsnz  <= msnz[NC];
      dsoz  <= msoz[NC];
    end
  end

  // ---------------- square roots of 12*|n|^2 * 4^FB, one root bit per stage
  // lane 0: new triangle, lane 1: old triangle
  logic [XW-1:0]   rx    [RW+1][2];
  logic [REMW-1:0] rrem  [RW+1][2];
  logic [RW-1:0]   rroot [RW+1][2];
  logic            rv    [RW+1];
  logic [SW-1:0]   rsn   [RW+1], rso [RW+1];
  logic            rdeny [RW+1], rsnz [RW+1], rsoz [RW+1];
  logic [PW+3:0]   x12   [2];

  always_comb begin
    x12[0] = ({4'b0, n2n} << 3) + ({4'b0, n2n} << 2);
    x12[1] = ({4'b0, n2o} << 3) + ({4'b0, n2o} << 2);
    for (int l = 0; l < 2; l++) begin
      rx[0][l]    = {x12[l], {(2 * FB){1'b0}}};
      rrem[0][l]  = '0;
      rroot[0][l] = '0;
    end
    rv[0]    = v4;
    rsn[0]   = dsn;
    rso[0]   = dso;
    rdeny[0] = ddeny;
    rsnz[0]  = dsnz;
    rsoz[0]  = dsoz;
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [REMW-1:0] r2 [2], tr [2];
    logic            ge [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        r2[l] = {rrem[k][l][REMW-3:0], rx[k][l][XW-1 -: 2]};
        tr[l] = REMW'({rroot[k][l], 2'b01});
        ge[l] = (r2[l] >= tr[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rv[k+1] <= 1'b0;
      end else if (ctl.adv) begin
        rv[k+1] <= rv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        for (int l = 0; l < 2; l++) begin
          rx[k+1][l]    <= rx[k][l] << 2;
          rrem[k+1][l]  <= ge[l] ? (r2[l] - tr[l]) : r2[l];
          rroot[k+1][l] <= {rroot[k][l][RW-2:0], ge[l]};
        end
        rsn[k+1]   <= rsn[k];
        rso[k+1]   <= rso[k];
        rdeny[k+1] <= rdeny[k];
        rsnz[k+1]  <= rsnz[k];
        rsoz[k+1]  <= rsoz[k];
      end
    end
  end

  // ---------------- division root / S, saturation check first
  logic [CW-1:0] qrem  [QW+1][2];
  logic [SW-1:0] qs    [QW+1][2];
  logic [QW-1:0] qq    [QW+1][2];
  logic          qovf  [QW+1][2];
  logic          qv    [QW+1];
  logic          qdeny [QW+1], qsnz [QW+1], qsoz [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      qv[0] <= 1'b0;
    end else if (ctl.adv) begin
      qv[0] <= rv[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      qrem[0][0] <= CW'(rroot[RW][0]);
      qrem[0][1] <= CW'(rroot[RW][1]);
      qs[0][0]   <= rsn[RW];
      qs[0][1]   <= rso[RW];
      qovf[0][0] <= CW'(rroot[RW][0]) >= {rsn[RW], {QW{1'b0}}};
      qovf[0][1] <= CW'(rroot[RW][1]) >= {rso[RW], {QW{1'b0}}};
      qq[0][0]   <= '0;
      qq[0][1]   <= '0;
      qdeny[0]   <= rdeny[RW];
      qsnz[0]    <= rsnz[RW];
      qsoz[0]    <= rsoz[RW];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [CW-1:0] dsh [2];
    logic          ge  [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        dsh[l] = CW'(qs[k][l]) << (FB - k);
        ge[l]  = (qrem[k][l] >= dsh[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        qv[k+1] <= 1'b0;
      end else if (ctl.adv) begin
        qv[k+1] <= qv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        for (int l = 0; l < 2; l++) begin
          qrem[k+1][l] <= ge[l] ? (qrem[k][l] - dsh[l]) : qrem[k][l];
          qs[k+1][l]   <= qs[k][l];
          qq[k+1][l]   <= {qq[k][l][QW-2:0], ge[l]};
          qovf[k+1][l] <= qovf[k][l];
        end
        qdeny[k+1] <= qdeny[k];
        qsnz[k+1]  <= qsnz[k];
        qsoz[k+1]  <= qsoz[k];
      end
    end
  end

  // ---------------- clamp compactness, select penalty
  logic [QW-1:0] cmp_new, cmp_old, lim, pen;

  always_comb begin
    cmp_new = (qovf[QW][0] || qq[QW][0] > ONE) ? ONE : qq[QW][0];
    cmp_old = (qovf[QW][1] || qq[QW][1] > ONE) ? ONE : qq[QW][1];
    // degenerate old triangle: use the target as is
    lim = (qsoz[QW] || target < cmp_old) ? target : cmp_old;
    pen = '0;
    if (!qdeny[QW] && !qsnz[QW] && cmp_new < target && lim > cmp_new) begin
      pen = lim - cmp_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.adv) begin
      out_valid <= qv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      out_deny    <= qdeny[QW];
      out_penalty <= pen;
    end
  end

endmodule

FILE: rtl/edge_collapse_triangle_penalty.sv
// Edge-collapse triangle penalty, top level: handshake, target register, datapath.
// The datapath pipelines NC = ceil((2*COORD_BITS+2)/16) product slices and
// RW = 2*COORD_BITS + 4 + FRAC_BITS root bits.
// Throughput: one transfer per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous, rst high) clears all valid bits and the target to 0.
module edge_collapse_triangle_penalty import ectp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  ectp_in_if.sink           item,
  ectp_out_if.source        result,
  input  logic              cfg_we,
  input  logic [FRAC_BITS:0] cfg_data
);

  ectp_ctl_t                    ctl;
  logic [FRAC_BITS:0]           target;
  logic signed [COORD_BITS-1:0] pts [NUM_PTS];
  logic                         dp_valid, dp_deny;
  logic [FRAC_BITS:0]           dp_penalty;

  // target register
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (cfg_we) begin
      target <= cfg_data;
    end
  end

  // advance whenever the output register is free or being drained
  assign ctl.adv    = !dp_valid || result.ready;
  assign ctl.valid  = item.valid;
  assign item.ready = ctl.adv;

  assign pts[P_NEW+0]   = item.new_x;
  assign pts[P_NEW+1]   = item.new_y;
  assign pts[P_NEW+2]   = item.new_z;
  assign pts[P_OLD+0]   = item.old_x;
  assign pts[P_OLD+1]   = item.old_y;
  assign pts[P_OLD+2]   = item.old_z;
  assign pts[P_LEFT+0]  = item.left_x;
  assign pts[P_LEFT+1]  = item.left_y;
  assign pts[P_LEFT+2]  = item.left_z;
  assign pts[P_RIGHT+0] = item.right_x;
  assign pts[P_RIGHT+1] = item.right_y;
  assign pts[P_RIGHT+2] = item.right_z;

  ectp_datapath #(
    .CB (COORD_BITS),
    .FB (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .pts         (pts),
    .target      (target),
    .out_valid   (dp_valid),
    .out_deny    (dp_deny),
    .out_penalty (dp_penalty)
  );

  assign result.valid   = dp_valid;
  assign result.deny    = dp_deny;
  assign result.penalty = dp_penalty;

`ifndef SYNTHESIS
  // a flipped triangle never carries a penalty
  a_deny_no_penalty: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.deny |-> result.penalty == '0)
    else $error("penalty nonzero on denied collapse");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid after reset");
`endif

endmodule

FILE: test/tb_edge_collapse_triangle_penalty.sv
// Testbench for edge_collapse_triangle_penalty: drives triangle items, predicts deny and
// penalty in exact wide integer math and checks every result transfer in order.
// Depends on ectp_pkg, the ectp_in_if/ectp_out_if interfaces and the block's RTL.
`timescale 1ns / 100ps

module tb_edge_collapse_triangle_penalty;
  import ectp_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int PIPE_CYCLES = 95;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 100;
  localparam logic [FB:0] ONE_Q = (FB+1)'(1) << FB;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic [NUM_PTS*CB-1:0] tri_t;
  typedef logic signed [255:0] wint_t;
  typedef struct packed {
    logic        deny;
    logic [FB:0] penalty;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [FB:0] cfg_data = '0;

  ectp_in_if  #(.CB(CB)) item_ch ();
  ectp_out_if #(.FB(FB)) result_ch ();

  edge_collapse_triangle_penalty #(.COORD_BITS(CB), .FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst(rst), .item(item_ch.sink), .result(result_ch.source),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  tri_t pending_tris[$];
  verdict_t expected_verdicts[$];
  logic [FB:0] target_q = '0;
  int mismatches = 0;
  int checked = 0;
  int denied = 0;
  int penalized = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;

  function automatic coord_t pt(tri_t t, int i);
    return t[i*CB +: CB];
  endfunction

  // Floor square root of an unsigned wide value
  function automatic logic [255:0] wide_isqrt(logic [255:0] x);
    logic [255:0] res, bitv;
    res = '0;
    bitv = 256'd1 << 254;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Compactness in Q1.FB, truncated and clamped to 1.0; edge_sum nonzero
  function automatic logic [FB:0] compactness(wint_t n2, wint_t edge_sum);
    logic [255:0] q;
    q = wide_isqrt(n2 * 12 * (256'd1 << (2*FB))) / edge_sum;
    return (q > ONE_Q) ? ONE_Q : q[FB:0];
  endfunction

  function automatic verdict_t predict_penalty(tri_t t, logic [FB:0] target);
    wint_t pn[3], po[3], pl[3], pr[3], a[3], bo[3], bn[3], cn[3], co[3];
    wint_t nold[3], nnew[3], aa, sn, so;
    logic [FB:0] newc, oldc, m;
    verdict_t v;
    for (int i = 0; i < 3; i++) begin
      pn[i] = pt(t, P_NEW + i);
      po[i] = pt(t, P_OLD + i);
      pl[i] = pt(t, P_LEFT + i);
      pr[i] = pt(t, P_RIGHT + i);
      a[i] = pr[i] - pl[i];
      bo[i] = po[i] - pl[i];
      bn[i] = pn[i] - pl[i];
      cn[i] = pn[i] - pr[i];
      co[i] = po[i] - pr[i];
    end
    nold[0] = a[1]*bo[2] - a[2]*bo[1];
    nold[1] = a[2]*bo[0] - a[0]*bo[2];
    nold[2] = a[0]*bo[1] - a[1]*bo[0];
    nnew[0] = a[1]*bn[2] - a[2]*bn[1];
    nnew[1] = a[2]*bn[0] - a[0]*bn[2];
    nnew[2] = a[0]*bn[1] - a[1]*bn[0];
    v = '0;
    // flipped normal: deny, no penalty
    if (nold[0]*nnew[0] + nold[1]*nnew[1] + nold[2]*nnew[2] < 0) begin
      v.deny = 1'b1;
      return v;
    end
    aa = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
    sn = aa + bn[0]*bn[0] + bn[1]*bn[1] + bn[2]*bn[2] + cn[0]*cn[0] + cn[1]*cn[1]
         + cn[2]*cn[2];
    if (sn != 0) begin
      newc = compactness(nnew[0]*nnew[0] + nnew[1]*nnew[1] + nnew[2]*nnew[2], sn);
      if (newc < target) begin
        so = aa + bo[0]*bo[0] + bo[1]*bo[1] + bo[2]*bo[2] + co[0]*co[0] + co[1]*co[1]
             + co[2]*co[2];
        if (so == 0) begin
          m = target;
        end else begin
          oldc = compactness(nold[0]*nold[0] + nold[1]*nold[1] + nold[2]*nold[2], so);
          m = (target < oldc) ? target : oldc;
        end
        if (m > newc) v.penalty = m - newc;
      end
    end
    return v;
  endfunction

  function automatic tri_t pack_tri(coord_t c[NUM_PTS]);
    tri_t t;
    for (int i = 0; i < NUM_PTS; i++) t[i*CB +: CB] = c[i];
    return t;
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  // Random item: mostly local triangles with a perturbed collapse, plus noise
  function automatic tri_t random_tri();
    coord_t c[NUM_PTS];
    int kind, span;
    int cen[3];
    kind = $urandom_range(0, 9);
    span = 1 << $urandom_range(1, 12);
    for (int k = 0; k < 3; k++) cen[k] = $urandom_range(0, 16760000) - 8380000;
    for (int i = 0; i < NUM_PTS; i++) begin
      if (kind < 2) c[i] = rand_coord();
      else c[i] = coord_t'(cen[i%3] + $urandom_range(0, 2*span) - span);
    end
    if (kind == 2) begin
      // mirror old through the fixed edge midpoint: often a flip
      for (int k = 0; k < 3; k++)
        c[P_NEW+k] = coord_t'(int'(c[P_LEFT+k]) + int'(c[P_RIGHT+k]) - int'(c[P_OLD+k]));
    end else if (kind == 3) begin
      for (int k = 0; k < 3; k++) c[P_NEW+k] = c[P_OLD+k] + coord_t'($urandom_range(0, 2) - 1);
    end else if (kind == 4) begin
      for (int k = 0; k < 3; k++) c[($urandom_range(0, 1) ? P_NEW : P_OLD)+k] = c[P_LEFT+k];
    end
    return pack_tri(c);
  endfunction

  function automatic tri_t uniform_tri(coord_t v);
    coord_t c[NUM_PTS];
    for (int i = 0; i < NUM_PTS; i++) c[i] = v;
    return pack_tri(c);
  endfunction

  function automatic tri_t shaped_tri(int nx, int ny, int ox, int oy, int rx);
    coord_t c[NUM_PTS];
    for (int i = 0; i < NUM_PTS; i++) c[i] = '0;
    c[P_NEW] = coord_t'(nx); c[P_NEW+1] = coord_t'(ny);
    c[P_OLD] = coord_t'(ox); c[P_OLD+1] = coord_t'(oy);
    c[P_RIGHT] = coord_t'(rx);
    return pack_tri(c);
  endfunction

  task automatic load_directed();
    coord_t c[NUM_PTS];
    coord_t mx, mn;
    mx = {1'b0, {(CB-1){1'b1}}};
    mn = {1'b1, {(CB-1){1'b0}}};
    pending_tris.push_back(uniform_tri(mx));
    pending_tris.push_back(uniform_tri(mn));
    pending_tris.push_back(uniform_tri('0));        // both triangles degenerate
    pending_tris.push_back(shaped_tri(50, 87, 50, 87, 100)); // near equilateral, unchanged
    pending_tris.push_back(shaped_tri(50, -87, 50, 87, 100)); // flipped normal
    pending_tris.push_back(shaped_tri(0, 0, 50, 87, 100));    // new on left: zero dot
    pending_tris.push_back(shaped_tri(50, 87, 0, 0, 100));    // old triangle degenerate
    pending_tris.push_back(shaped_tri(50, 3, 50, 87, 100));   // thin new triangle
    pending_tris.push_back(shaped_tri(900, 5, 50, 87, 100));  // long sliver
    pending_tris.push_back(shaped_tri(50, 1, 50, 1, 100));    // both thin
    pending_tris.push_back(shaped_tri(1, 1, -1, -1, 2));      // tiny flip
    // extreme coordinates with alternating signs
    for (int i = 0; i < NUM_PTS; i++) c[i] = (i % 2) ? mx : mn;
    pending_tris.push_back(pack_tri(c));
    for (int i = 0; i < NUM_PTS; i++) c[i] = (i % 3 == 0) ? mx : ((i % 3 == 1) ? mn : '0);
    pending_tris.push_back(pack_tri(c));
    for (int i = 0; i < NUM_PTS; i++) c[i] = '0;
    c[P_RIGHT] = mx; c[P_LEFT] = mn; c[P_OLD+1] = mx; c[P_NEW+1] = mn;
    pending_tris.push_back(pack_tri(c));
    c[P_NEW+1] = mx; c[P_NEW+2] = mn;
    pending_tris.push_back(pack_tri(c));
    for (int i = 0; i < NUM_PTS; i++) c[i] = {CB{1'b1}};
    c[P_RIGHT] = '0; c[P_OLD+1] = coord_t'(7); c[P_NEW+1] = coord_t'(6); c[P_NEW+2] = mx;
    pending_tris.push_back(pack_tri(c));
  endtask

  // Sender: bursts of transfers separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || item_ch.ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        item_ch.valid <= 1'b0;
      end else if (pending_tris.size() > 0) begin
        tri_t t;
        t = pending_tris.pop_front();
        item_ch.valid <= 1'b1;
        {item_ch.right_z, item_ch.right_y, item_ch.right_x,
         item_ch.left_z, item_ch.left_y, item_ch.left_x,
         item_ch.old_z, item_ch.old_y, item_ch.old_x,
         item_ch.new_z, item_ch.new_y, item_ch.new_x} <= t;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  initial begin
    item_ch.valid = 1'b0;
    {item_ch.new_x, item_ch.new_y, item_ch.new_z, item_ch.old_x, item_ch.old_y,
     item_ch.old_z, item_ch.left_x, item_ch.left_y, item_ch.left_z, item_ch.right_x,
     item_ch.right_y, item_ch.right_z} = '0;
    result_ch.ready = 1'b0;
  end

  // Receiver: stall pattern mode picked at random from three; long hold on request
  int rx_cycle = 0;
  int rx_mode = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 2);
    if (hold_req && hold_left == 0) begin
      hold_req <= 1'b0;
      hold_left <= HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ch.ready <= (hold_left == 1);
    end else begin
      case (rx_mode)
        0: result_ch.ready <= 1'b1;
        1: result_ch.ready <= ($urandom_range(0, 1) == 1);
        default: result_ch.ready <= (rx_cycle % 7 > 2);
      endcase
    end
  end

  // Predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (item_ch.valid && item_ch.ready)
        expected_verdicts.push_back(predict_penalty(
          {item_ch.right_z, item_ch.right_y, item_ch.right_x,
           item_ch.left_z, item_ch.left_y, item_ch.left_x,
           item_ch.old_z, item_ch.old_y, item_ch.old_x,
           item_ch.new_z, item_ch.new_y, item_ch.new_x}, target_q));
      if (result_ch.valid && result_ch.ready) begin
        if (expected_verdicts.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected result: deny=%0d penalty=%0d",
                     result_ch.deny, result_ch.penalty);
        end else begin
          verdict_t e;
          e = expected_verdicts.pop_front();
          checked <= checked + 1;
          if (e.deny) denied <= denied + 1;
          if (e.penalty != 0) penalized <= penalized + 1;
          if (e.deny !== result_ch.deny || e.penalty !== result_ch.penalty) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch #%0d: expected deny=%0d penalty=%0d, got deny=%0d penalty=%0d",
                       checked, e.deny, e.penalty, result_ch.deny, result_ch.penalty);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("edge_collapse_triangle_penalty test failed");
      $finish;
    end
  end

  task automatic drain();
    while (pending_tris.size() > 0 || item_ch.valid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (PIPE_CYCLES + 5) @(posedge clk);
  endtask

  task automatic write_target(logic [FB:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    target_q = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [FB:0] targets[5];
    targets[0] = ONE_Q;
    targets[1] = '0;
    targets[2] = {(FB+1){1'b1}};
    targets[3] = 17'd45000;
    targets[4] = (FB+1)'($urandom_range(1, ONE_Q));
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < 5; ph++) begin
      write_target(targets[ph]);
      if (ph == 0) load_directed();
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) pending_tris.push_back(random_tri());
      drain();
    end
    $display("checked %0d results over 5 target settings: %0d denied, %0d with a penalty",
             checked, denied, penalized);
    if (mismatches == 0) begin
      $display("edge_collapse_triangle_penalty test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("edge_collapse_triangle_penalty test failed");
    end
    $finish;
  end

endmodule
